/* design/isti_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isti_pkg
// Shared types, widths and constants of the IMU sample time interpolator.
// ---------------------------------------------------------------------------
package isti_pkg;

	localparam int TimeBits   = 32;
	localparam int SampleBits = 16;
	localparam int FracBits   = 16;
	localparam int NumCh      = 10;
	localparam int NumQuat    = 4;
	localparam int QuatBase   = 6;

	localparam int InBytes  = (TimeBits + NumCh * SampleBits + 7) / 8;
	localparam int OutBytes = (TimeBits + NumCh * SampleBits + 7) / 8;
	localparam int InBits   = InBytes * 8;
	localparam int OutBits  = OutBytes * 8;

	// weight holds 0 .. 2^FracBits
	localparam int WBits = FracBits + 1;

	typedef logic signed [SampleBits-1:0] sample_t;
	typedef logic [TimeBits-1:0]          stamp_t;
	typedef logic [WBits-1:0]             weight_t;

	// request kinds carried on tuser
	localparam logic ReqSample = 1'b0;
	localparam logic ReqSync   = 1'b1;

	// lane control from the sequencer
	typedef struct packed {
		logic    load;
		weight_t fw;
		weight_t bw;
	} lane_ctl_t;

	// normalizer control
	typedef struct packed {
		logic start;
	} norm_ctl_t;

endpackage

/* design/imu_sample_time_interpolator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_sample_time_interpolator_unit
// Resamples an IMU stream at sync times: ten blend lanes plus a quaternion
// renormalizer merging the four quaternion lanes.
//
// channel   dir  payload
// s_axis    in   tdata {quat_w..acc_x, stamp}, tuser req_type
// m_axis    out  tdata {out_quat_w..out_acc_x, out_stamp}
//
// A sample that serves a pending sync occupies the block for these steps:
// the accept, 16 weight divider steps (one when the sync time reaches the
// new sample), one blend, 4 squares, 17 root steps, four divide passes
// (load, 32 steps, store), the done strobe and the output transfer. Other
// transactions are taken while idle. Reset clears the kept-sample and
// pending flags. A stalled output holds the block busy until taken.
// ---------------------------------------------------------------------------
module imu_sample_time_interpolator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// stamp, acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z, quat_x, quat_y, quat_z, quat_w
	input  logic [isti_pkg::InBits-1:0]   s_axis_tdata,
	// req_type
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_stamp, out_acc_x..z, out_gyr_x..z, out_quat_x..w
	output logic [isti_pkg::OutBits-1:0]  m_axis_tdata
);
	localparam int TB = isti_pkg::TimeBits;
	localparam int SB = isti_pkg::SampleBits;
	localparam int NC = isti_pkg::NumCh;
	localparam int FB = isti_pkg::FracBits;
	localparam int CB = $clog2(FB + 1);

	typedef enum logic [2:0] {IDLE, DIVW, BLEND, NORM, OUT} st_t;
	st_t st_q;

	logic               prev_valid_q, pend_valid_q;
	isti_pkg::stamp_t   prev_stamp_q, pend_stamp_q;
	isti_pkg::sample_t  prev_ch_q [NC];
	isti_pkg::sample_t  cur_ch_q [NC];
	isti_pkg::sample_t  in_ch [NC];
	isti_pkg::sample_t  lane_res [NC];
	isti_pkg::sample_t  qn [isti_pkg::NumQuat];
	isti_pkg::sample_t  qi [isti_pkg::NumQuat];
	isti_pkg::stamp_t   t_in;
	isti_pkg::weight_t  bw_q;
	logic [TB:0]        rem_q;
	isti_pkg::stamp_t   den_q;
	logic [CB-1:0]      cnt_q;
	logic [TB+1:0]      dsub;
	logic               acc;
	logic               norm_done;
	isti_pkg::lane_ctl_t lctl;
	isti_pkg::norm_ctl_t nctl;

	assign t_in = s_axis_tdata[TB-1:0];
	for (genvar i = 0; i < NC; i++) begin : g_in
		assign in_ch[i] = s_axis_tdata[TB + i*SB +: SB];
	end

	assign s_axis_tready = (st_q == IDLE);
	assign acc  = s_axis_tvalid && s_axis_tready;
	assign dsub = {rem_q, 1'b0} - {2'b0, den_q};

	assign lctl.load = (st_q == BLEND);
	assign lctl.bw   = bw_q;
	assign lctl.fw   = isti_pkg::WBits'(1 << FB) - bw_q;
	// one-cycle kick; the lane results are registered on the same edge
	assign nctl.start = (st_q == BLEND);

	for (genvar i = 0; i < NC; i++) begin : g_lane
		isti_lane u_lane (
			.clk   (clk),
			.ctl   (lctl),
			.old_s (prev_ch_q[i]),
			.new_s (cur_ch_q[i]),
			.res   (lane_res[i])
		);
	end
	for (genvar i = 0; i < isti_pkg::NumQuat; i++) begin : g_q
		assign qi[i] = lane_res[isti_pkg::QuatBase + i];
	end

	isti_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (nctl),
		.q_in   (qi),
		.q_out  (qn),
		.done   (norm_done)
	);

	logic started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= IDLE;
			prev_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			prev_stamp_q <= '0;
			pend_stamp_q <= '0;
			started_q    <= 1'b0;
			for (int i = 0; i < NC; i++) prev_ch_q[i] <= '0;
		end else begin
			case (st_q)
				IDLE: if (acc) begin
					if (s_axis_tuser == isti_pkg::ReqSync) begin
						if (prev_valid_q && !pend_valid_q && t_in >= prev_stamp_q) begin
							pend_valid_q <= 1'b1;
							pend_stamp_q <= t_in;
						end
					end else if (pend_valid_q && prev_valid_q && t_in >= pend_stamp_q) begin
						for (int i = 0; i < NC; i++) cur_ch_q[i] <= in_ch[i];
						den_q <= t_in - prev_stamp_q;
						rem_q <= {1'b0, pend_stamp_q - prev_stamp_q};
						bw_q  <= '0;
						cnt_q <= CB'(FB);
						prev_stamp_q <= t_in;
						st_q  <= DIVW;
					end else begin
						for (int i = 0; i < NC; i++) prev_ch_q[i] <= in_ch[i];
						prev_stamp_q <= t_in;
						prev_valid_q <= 1'b1;
					end
				end
				DIVW: begin
					if ({1'b0, rem_q} >= {2'b0, den_q}) begin
						// numerator reaches the span: full back weight
						bw_q <= isti_pkg::WBits'(1 << FB);
						st_q <= BLEND;
					end else begin
						if (!dsub[TB+1]) begin
							rem_q <= dsub[TB:0];
							bw_q  <= {bw_q[FB-1:0], 1'b1};
						end else begin
							rem_q <= {rem_q[TB-1:0], 1'b0};
							bw_q  <= {bw_q[FB-1:0], 1'b0};
						end
						cnt_q <= cnt_q - CB'(1);
						if (cnt_q == CB'(1)) st_q <= BLEND;
					end
				end
				BLEND: begin
					st_q      <= NORM;
					started_q <= 1'b0;
				end
				NORM: begin
					started_q <= 1'b1;
					if (norm_done && started_q) begin
						st_q <= OUT;
						for (int i = 0; i < NC; i++) prev_ch_q[i] <= cur_ch_q[i];
						prev_valid_q <= 1'b1;
						pend_valid_q <= 1'b0;
					end
				end
				OUT: if (m_axis_tready) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (st_q == OUT);
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[TB-1:0] = pend_stamp_q;
		for (int i = 0; i < isti_pkg::QuatBase; i++)
			m_axis_tdata[TB + i*SB +: SB] = lane_res[i];
		for (int i = 0; i < isti_pkg::NumQuat; i++)
			m_axis_tdata[TB + (isti_pkg::QuatBase + i)*SB +: SB] = qn[i];
	end
endmodule

/* design/isti_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isti_lane
// One channel blend lane: front*old + back*new, round, saturate.
// Result is registered on load.
// ---------------------------------------------------------------------------
module isti_lane (
	input  logic                clk,
	input  isti_pkg::lane_ctl_t ctl,
	input  isti_pkg::sample_t   old_s,
	input  isti_pkg::sample_t   new_s,
	output isti_pkg::sample_t   res
);
	localparam int PB = isti_pkg::SampleBits + isti_pkg::WBits + 2;

	logic signed [PB-1:0] prod_a, prod_b, sum, rnd, shr;
	logic signed [PB-1:0] hi, lo;
	isti_pkg::sample_t    res_q;

	always_comb begin
		prod_a = PB'(old_s) * $signed({1'b0, ctl.fw});
		prod_b = PB'(new_s) * $signed({1'b0, ctl.bw});
		sum    = prod_a + prod_b;
		rnd    = sum + (PB'(1) <<< (isti_pkg::FracBits - 1));
		shr    = rnd >>> isti_pkg::FracBits;
		hi     = PB'((1 << (isti_pkg::SampleBits - 1)) - 1);
		lo     = -hi - PB'(1);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (shr > hi)
				res_q <= hi[isti_pkg::SampleBits-1:0];
			else if (shr < lo)
				res_q <= lo[isti_pkg::SampleBits-1:0];
			else
				res_q <= shr[isti_pkg::SampleBits-1:0];
		end
	end

	assign res = res_q;
endmodule

/* design/isti_norm.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isti_norm
// Quaternion renormalizer: sum of squares, bit-serial square root, then a
// shared restoring divider used once per component.
// ---------------------------------------------------------------------------
module isti_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  isti_pkg::norm_ctl_t ctl,
	input  isti_pkg::sample_t   q_in [isti_pkg::NumQuat],
	output isti_pkg::sample_t   q_out [isti_pkg::NumQuat],
	output logic                done
);
	localparam int SB  = isti_pkg::SampleBits;
	localparam int N2B = 2 * SB + 2;          // sum of four squares
	localparam int RB  = SB + 1;              // root width
	localparam int NB  = SB + SB;             // magnitude << (SB-1) plus round
	localparam int SqC = N2B / 2;             // root iterations
	localparam int CB  = $clog2(NB + 1);

	typedef enum logic [2:0] {IDLE, SQ, ROOT, DIV, NEXT} st_t;
	st_t st_q;

	logic [N2B-1:0] n2_q, rem_q;
	logic [RB-1:0]  root_q;
	logic [CB-1:0]  cnt_q;
	logic [1:0]     idx_q;
	logic [2:0]     sq_q;
	logic [NB-1:0]  num_q;
	logic [RB:0]    drem_q;
	logic           done_q;
	isti_pkg::sample_t res_q [isti_pkg::NumQuat];

	logic [SB-1:0]  mag;
	logic [N2B-1:0] msq;
	logic [N2B+1:0] trial;
	logic [RB:0]    dtrial;
	logic [NB-1:0]  qlim;
	logic           neg;

	always_comb begin
		neg   = q_in[idx_q][SB-1];
		mag   = neg ? SB'(-q_in[idx_q]) : SB'(q_in[idx_q]);
		msq   = N2B'(mag) * N2B'(mag);
		trial = {rem_q, n2_q[N2B-1 -: 2]} - {root_q, 2'b01};
		dtrial = {drem_q[RB-1:0], num_q[NB-1]} - {1'b0, root_q};
		qlim  = neg ? NB'(1 << (SB - 1)) : NB'((1 << (SB - 1)) - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= IDLE;
			done_q <= 1'b0;
			sq_q   <= '0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				IDLE: if (ctl.start) begin
					n2_q  <= '0;
					idx_q <= '0;
					st_q  <= SQ;
				end
				SQ: begin
					n2_q  <= n2_q + msq;
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'(isti_pkg::NumQuat - 1)) begin
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= CB'(SqC);
						st_q   <= ROOT;
					end
				end
				ROOT: begin
					// two bits of the radicand per step
					n2_q <= n2_q << 2;
					if (!trial[N2B+1]) begin
						rem_q  <= trial[N2B-1:0];
						root_q <= {root_q[RB-2:0], 1'b1};
					end else begin
						rem_q  <= {rem_q[N2B-3:0], n2_q[N2B-1 -: 2]};
						root_q <= {root_q[RB-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CB'(1);
					if (cnt_q == CB'(1)) begin
						idx_q <= '0;
						st_q  <= NEXT;
					end
				end
				NEXT: begin
					num_q  <= (NB'(mag) << (SB - 1)) + NB'(root_q >> 1);
					drem_q <= '0;
					cnt_q  <= CB'(NB);
					sq_q   <= '0;
					st_q   <= DIV;
				end
				DIV: begin
					num_q <= {num_q[NB-2:0], ~dtrial[RB]};
					if (!dtrial[RB])
						drem_q <= {1'b0, dtrial[RB-1:0]};
					else
						drem_q <= {drem_q[RB-1:0], num_q[NB-1]};
					cnt_q <= cnt_q - CB'(1);
					if (cnt_q == CB'(1)) begin
						// quotient now in num_q (after this shift)
						st_q <= IDLE;
						sq_q <= 3'd1;
					end
				end
				default: st_q <= IDLE;
			endcase

			// finish one component the cycle after its divide ends
			if (sq_q == 3'd1 && st_q == IDLE) begin
				sq_q <= '0;
				if (root_q == '0)
					res_q[idx_q] <= '0;
				else if (num_q > qlim)
					res_q[idx_q] <= neg ? SB'(-qlim) : SB'(qlim);
				else
					res_q[idx_q] <= neg ? SB'(-num_q) : SB'(num_q);
				if (idx_q == 2'(isti_pkg::NumQuat - 1))
					done_q <= 1'b1;
				else begin
					idx_q <= idx_q + 2'd1;
					st_q  <= NEXT;
				end
			end
		end
	end

	assign q_out = res_q;
	assign done  = done_q;
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives IMU samples and sync requests into the interpolator, predicts the
// interpolated and renormalized output for each served sync time, and checks
// every output transaction field by field under random idles and stalls.
// ---------------------------------------------------------------------------
module tb_top;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [isti_pkg::InBits-1:0]   s_axis_tdata;
	logic                          s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [isti_pkg::OutBits-1:0]  m_axis_tdata;

	imu_sample_time_interpolator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	typedef struct packed {
		isti_pkg::sample_t [isti_pkg::NumCh-1:0] ch;
		isti_pkg::stamp_t                        stamp;
	} frame_t;

	localparam int WatchLimit = 20000;
	localparam int ExpDepth   = 2048;

	// predictor state
	logic              kept_valid;
	isti_pkg::stamp_t  kept_stamp;
	isti_pkg::sample_t kept_ch [isti_pkg::NumCh];
	logic              sync_valid;
	isti_pkg::stamp_t  sync_stamp;

	// expected frames, written by the driver side, read by the checker
	frame_t            exp_mem [ExpDepth];
	int                exp_wr = 0;
	int                exp_rd = 0;
	int                n_err = 0;
	int                idle_cnt = 0;
	int                burst_left;
	isti_pkg::stamp_t  clock_now;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] res, bit_v;
		res   = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n   = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic string ch_name(int i);
		case (i)
			0: return "out_acc_x";
			1: return "out_acc_y";
			2: return "out_acc_z";
			3: return "out_gyr_x";
			4: return "out_gyr_y";
			5: return "out_gyr_z";
			6: return "out_quat_x";
			7: return "out_quat_y";
			8: return "out_quat_z";
			default: return "out_quat_w";
		endcase
	endfunction

	// apply one transaction to the predictor; store the expected frame if served
	task automatic predict_interp(logic kind, frame_t f);
		longint bw, fw, span, num, sumsq, r, m, q, lim, acc;
		longint mix [isti_pkg::NumCh];
		frame_t o;
		if (kind == isti_pkg::ReqSync) begin
			if (kept_valid && !sync_valid && f.stamp >= kept_stamp) begin
				sync_valid = 1'b1;
				sync_stamp = f.stamp;
			end
			return;
		end
		if (sync_valid && kept_valid && f.stamp >= sync_stamp) begin
			span = longint'(f.stamp) - longint'(kept_stamp);
			num  = longint'(sync_stamp) - longint'(kept_stamp);
			if (span == 0 || num >= span)
				bw = 64'sd1 << isti_pkg::FracBits;
			else
				bw = (num << isti_pkg::FracBits) / span;
			fw = (64'sd1 << isti_pkg::FracBits) - bw;
			for (int i = 0; i < isti_pkg::NumCh; i++) begin
				acc    = longint'(kept_ch[i]) * fw + longint'(f.ch[i]) * bw
					+ (64'sd1 << (isti_pkg::FracBits - 1));
				mix[i] = sat16(acc >>> isti_pkg::FracBits);
			end
			sumsq = 0;
			for (int i = isti_pkg::QuatBase; i < isti_pkg::NumCh; i++)
				sumsq += mix[i] * mix[i];
			r = isqrt(sumsq);
			for (int i = isti_pkg::QuatBase; i < isti_pkg::NumCh; i++) begin
				if (r == 0) begin
					mix[i] = 0;
				end else begin
					m   = mix[i] < 0 ? -mix[i] : mix[i];
					q   = ((m << (isti_pkg::SampleBits - 1)) + (r >> 1)) / r;
					lim = mix[i] < 0 ? 32768 : 32767;
					if (q > lim)
						q = lim;
					mix[i] = mix[i] < 0 ? -q : q;
				end
			end
			o.stamp = sync_stamp;
			for (int i = 0; i < isti_pkg::NumCh; i++)
				o.ch[i] = isti_pkg::sample_t'(mix[i]);
			exp_mem[exp_wr] = o;
			exp_wr++;
			sync_valid = 1'b0;
		end
		for (int i = 0; i < isti_pkg::NumCh; i++)
			kept_ch[i] = f.ch[i];
		kept_stamp = f.stamp;
		kept_valid = 1'b1;
	endtask

	// send one transaction, with bursty random gaps ahead of it
	task automatic send_item(logic kind, frame_t f);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= isti_pkg::InBits'(f);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_interp(kind, f);
	endtask

	function automatic frame_t rand_frame(isti_pkg::stamp_t st);
		frame_t f;
		f.stamp = st;
		for (int i = 0; i < isti_pkg::NumCh; i++)
			f.ch[i] = isti_pkg::sample_t'($urandom);
		return f;
	endfunction

	function automatic frame_t const_frame(isti_pkg::stamp_t st, isti_pkg::sample_t v);
		frame_t f;
		f.stamp = st;
		for (int i = 0; i < isti_pkg::NumCh; i++)
			f.ch[i] = v;
		return f;
	endfunction

	// output checker
	always @(posedge clk) begin
		frame_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = frame_t'(m_axis_tdata);
			if (exp_rd == exp_wr) begin
				$error("unexpected transaction, out_stamp %0d", got.stamp);
				n_err++;
			end else begin
				want = exp_mem[exp_rd];
				exp_rd++;
				if (got.stamp !== want.stamp) begin
					$error("out_stamp: expected %0d, got %0d", want.stamp, got.stamp);
					n_err++;
				end
				for (int i = 0; i < isti_pkg::NumCh; i++)
					if (got.ch[i] !== want.ch[i]) begin
						$error("%s: expected %0d, got %0d", ch_name(i),
							want.ch[i], got.ch[i]);
						n_err++;
					end
			end
		end
	end

	// receiver stall pattern: runs of ready and not ready, with calm stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 9) == 0)
			m_axis_tready <= ~m_axis_tready | ($urandom_range(0, 2) == 0);
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WatchLimit) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic test_directed();
		// sync without any kept sample, then extremes of every field
		send_item(isti_pkg::ReqSync, const_frame(32'd50, '0));
		send_item(isti_pkg::ReqSample, const_frame(32'd100, 16'sh7fff));
		send_item(isti_pkg::ReqSync, const_frame(32'd90, '0));     // before kept time
		send_item(isti_pkg::ReqSync, const_frame(32'd150, '0));
		send_item(isti_pkg::ReqSync, const_frame(32'd160, '0));    // ignored, one pending
		send_item(isti_pkg::ReqSample, const_frame(32'd120, '0));  // before pending time
		send_item(isti_pkg::ReqSample, const_frame(32'd200, 16'sh8000));
		// zero span
		send_item(isti_pkg::ReqSync, const_frame(32'd200, '0));
		send_item(isti_pkg::ReqSample, const_frame(32'd200, 16'sh1234));
		// zero quaternion norm
		send_item(isti_pkg::ReqSync, const_frame(32'd250, '0));
		send_item(isti_pkg::ReqSample, const_frame(32'd300, '0));
		send_item(isti_pkg::ReqSync, const_frame(32'd300, '0));
		send_item(isti_pkg::ReqSample, const_frame(32'd400, '0));
		// large stamps near the top of the range
		send_item(isti_pkg::ReqSample, const_frame(32'hffff_ff00, 16'sh8000));
		send_item(isti_pkg::ReqSync, const_frame(32'hffff_ff80, '0));
		send_item(isti_pkg::ReqSample, const_frame(32'hffff_ffff, 16'sh7fff));
		send_item(isti_pkg::ReqSync, const_frame(32'hffff_ffff, '0));
		send_item(isti_pkg::ReqSample, rand_frame(32'hffff_ffff));
	endtask

	task automatic test_random_stream();
		isti_pkg::stamp_t st;
		int               n;
		frame_t           f;
		n = 0;
		// mostly well-formed: samples on a rising clock with syncs in between
		while (n < 1830) begin
			if ($urandom_range(0, 99) == 0) begin
				// restart time at random spot with full-range stamp bits
				clock_now = $urandom;
				if (clock_now > 32'hfff0_0000)
					clock_now = clock_now - 32'h0010_0000;
			end
			st = clock_now + $urandom_range(0, 3000);
			if ($urandom_range(0, 2) == 0) begin
				f = rand_frame(clock_now + $urandom_range(0, 3500));
				if ($urandom_range(0, 15) == 0)
					f.stamp = $urandom;                    // noise
				send_item(isti_pkg::ReqSync, f);
			end else begin
				f = rand_frame(st);
				send_item(isti_pkg::ReqSample, f);
				clock_now = st;
			end
			n++;
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = isti_pkg::ReqSample;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b1;
		kept_valid    = 1'b0;
		kept_stamp    = '0;
		sync_valid    = 1'b0;
		sync_stamp    = '0;
		for (int i = 0; i < isti_pkg::NumCh; i++)
			kept_ch[i] = '0;
		burst_left = 0;
		clock_now  = 32'd1000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		clock_now = 32'd5000;
		test_random_stream();
		s_axis_tvalid <= 1'b0;
		while (exp_rd != exp_wr)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (n_err == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
